@@ sv/eigenmode_trilinear_lookup_assert.svh @@
// assertion macros for the eigenmode trilinear lookup
// depends on nothing; included by the top level
`ifndef EIGENMODE_TRILINEAR_LOOKUP_ASSERT_SVH
`define EIGENMODE_TRILINEAR_LOOKUP_ASSERT_SVH

// same-cycle implication, held off during reset
`define ETL_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("eigenmode lookup check failed");

// next-cycle implication, held off during reset
`define ETL_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("eigenmode lookup check failed");

`endif

@@ sv/etl_pkg.sv @@
// shared types and constants of the eigenmode trilinear lookup
// depends on nothing
package etl_pkg;

  localparam int K_W       = 13;
  localparam int ADDR_W    = 17;
  localparam int WORD_W    = 32;
  localparam int VEC_W     = 40;
  localparam int FRAC_W    = 16;
  localparam int SIDE_W    = 13;
  localparam int E_W       = 33;
  localparam int K2_W      = 26;
  localparam int DOT_W     = 46;
  localparam int NUM_W     = 58;
  localparam int DVD_W     = NUM_W + FRAC_W;
  localparam int DVS_W     = DOT_W;
  localparam int DIV_CNT_W = 7;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic signed [WORD_W-1:0] ONE_Q28 = 32'sh1000_0000;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 13'd64;

  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_QUERY = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_SIDE = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE, OP_WRITE, OP_LOAD, OP_PLAIN, OP_DIV_START, OP_DIV_END,
    OP_READ, OP_LERP, OP_MAC, OP_NUM, OP_FINISH
  } op_t;

  typedef enum logic [1:0] {
    DIV_FOLD, DIV_PLACE, DIV_FRAC, DIV_MODE
  } div_kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PLAIN, S_DSTART, S_DWAIT, S_READ, S_RDRAIN, S_LERP, S_MAC,
    S_NUM, S_FINISH
  } state_t;

  typedef struct packed {
    op_t       op;
    div_kind_t kind;
    logic [1:0] axis;
    logic [1:0] comp;
    logic [2:0] step;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
    logic mode;
  } status_t;

endpackage

@@ sv/etl_if.sv @@
// valid/ready channel interfaces for query items and result items
// depends on etl_pkg
interface etl_in_if;
  import etl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [ADDR_W-1:0]        table_address;
  logic signed [WORD_W-1:0] table_word;
  logic signed [K_W-1:0]    wave_x;
  logic signed [K_W-1:0]    wave_y;
  logic signed [K_W-1:0]    wave_z;
  modport source (output valid, opcode, table_address, table_word, wave_x, wave_y, wave_z,
                  input ready);
  modport sink (input valid, opcode, table_address, table_word, wave_x, wave_y, wave_z,
                output ready);
endinterface

interface etl_out_if;
  import etl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [VEC_W-1:0]  vec_x;
  logic signed [VEC_W-1:0]  vec_y;
  logic signed [VEC_W-1:0]  vec_z;
  logic signed [WORD_W-1:0] growth_value;
  logic                     saturated;
  modport source (output valid, vec_x, vec_y, vec_z, growth_value, saturated, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, growth_value, saturated, output ready);
endinterface

@@ sv/etl_ram.sv @@
// generic single-write, single-read ram with registered read data
// depends on nothing
module etl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ sv/etl_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// depends on etl_pkg; dividend arrives left-aligned to its significant bits
module etl_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [etl_pkg::DIV_CNT_W-1:0]  count,
  input  logic [etl_pkg::DVD_W-1:0]      dividend,
  input  logic [etl_pkg::DVS_W-1:0]      divisor,
  output logic                           busy,
  output logic [etl_pkg::DVD_W-1:0]      quotient,
  output logic [etl_pkg::DVS_W-1:0]      remainder
);
  import etl_pkg::*;

  logic [DVD_W-1:0]     dvd;
  logic [DVS_W-1:0]     dvs;
  logic [DVS_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W:0]       rem_sh;
  logic [DVS_W:0]       rem_diff;
  logic                 qbit;
  logic [DVS_W-1:0]     rem_next;

  // one shift-subtract step
  always_comb begin
    rem_sh   = {rem, dvd[DVD_W-1]};
    rem_diff = rem_sh - {1'b0, dvs};
    qbit     = (rem_sh >= {1'b0, dvs});
    rem_next = qbit ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= (count != '0);
      cnt  <= count;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // dividend shifts out, quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;
endmodule

@@ sv/etl_ctrl.sv @@
// controller state machine that sequences the lookup datapath
// depends on etl_pkg
module etl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_opcode,
  output logic             in_ready,
  input  etl_pkg::status_t status,
  output etl_pkg::cmd_t    cmd
);
  import etl_pkg::*;

  state_t     state, state_next;
  div_kind_t  kind, kind_next;
  logic [1:0] axis, axis_next;
  logic [1:0] comp, comp_next;
  logic [2:0] step, step_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= DIV_FOLD;
      axis  <= '0;
      comp  <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      axis  <= axis_next;
      comp  <= comp_next;
      step  <= step_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    kind_next  = kind;
    axis_next  = axis;
    comp_next  = comp;
    step_next  = step;
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.kind   = kind;
    cmd.axis   = axis;
    cmd.comp   = comp;
    cmd.step   = step;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OPC_WRITE) begin
            cmd.op = OP_WRITE;
          end else begin
            cmd.op = OP_LOAD;
            kind_next = DIV_FOLD;
            axis_next = '0;
            state_next = status.mode ? S_DSTART : S_PLAIN;
          end
        end
      end
      S_PLAIN: begin
        cmd.op = OP_PLAIN;
        state_next = S_FINISH;
      end
      S_DSTART: begin
        cmd.op = OP_DIV_START;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (!status.div_busy) begin
          cmd.op = OP_DIV_END;
          if (kind == DIV_MODE) begin
            if (axis == 2'd2) begin
              state_next = S_FINISH;
            end else begin
              axis_next = axis + 1'b1;
              state_next = S_NUM;
            end
          end else if (axis != 2'd2) begin
            axis_next = axis + 1'b1;
            state_next = S_DSTART;
          end else begin
            axis_next = '0;
            case (kind)
              DIV_FOLD:  begin kind_next = DIV_PLACE; state_next = S_DSTART; end
              DIV_PLACE: begin kind_next = DIV_FRAC;  state_next = S_DSTART; end
              default: begin
                step_next = '0;
                comp_next = '0;
                state_next = S_READ;
              end
            endcase
          end
        end
      end
      S_READ: begin
        cmd.op = OP_READ;
        step_next = step + 1'b1;
        if (step == 3'd7) begin
          state_next = S_RDRAIN;
        end
      end
      S_RDRAIN: begin
        step_next = '0;
        state_next = S_LERP;
      end
      S_LERP: begin
        cmd.op = OP_LERP;
        if (step == 3'd6) begin
          step_next = '0;
          if (comp == 2'd3) begin
            state_next = S_MAC;
          end else begin
            comp_next = comp + 1'b1;
            state_next = S_READ;
          end
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_MAC: begin
        cmd.op = OP_MAC;
        if (step == 3'd5) begin
          axis_next = '0;
          state_next = S_NUM;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_NUM: begin
        cmd.op = OP_NUM;
        kind_next = DIV_MODE;
        state_next = S_DSTART;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.op = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

@@ sv/etl_dp.sv @@
// lookup datapath: folding, grid placement, table reads, interpolation,
// scaling division and the result register; depends on etl_pkg, etl_ram, etl_div
module etl_dp #(
  parameter int TABLE_SIDE    = 32,
  parameter int MAX_GRID_SIDE = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  etl_pkg::cmd_t                     cmd,
  output etl_pkg::status_t                  status,
  input  logic [etl_pkg::ADDR_W-1:0]        table_address,
  input  logic signed [etl_pkg::WORD_W-1:0] table_word,
  input  logic signed [etl_pkg::K_W-1:0]    wave_x,
  input  logic signed [etl_pkg::K_W-1:0]    wave_y,
  input  logic signed [etl_pkg::K_W-1:0]    wave_z,
  input  logic                              mode_table_enable,
  input  logic [etl_pkg::SIDE_W-1:0]        grid_points_per_side,
  etl_out_if.source                         out_ch
);
  import etl_pkg::*;

  localparam int ZPLANES = TABLE_SIDE / 2 + 1;
  localparam int DEPTH   = TABLE_SIDE * TABLE_SIDE * ZPLANES * 4;
  localparam int AW      = $clog2(DEPTH);
  localparam int LW      = $clog2(TABLE_SIDE);
  localparam int NW      = LW + SIDE_W;
  localparam int HALF    = TABLE_SIDE / 2;

  logic signed [K_W-1:0]    k [3];
  logic [SIDE_W-1:0]        side;
  logic [SIDE_W-1:0]        ik [3];
  logic [SIDE_W-1:0]        rr [3];
  logic [LW-1:0]            lo [3];
  logic [LW-1:0]            hi [3];
  logic [FRAC_W-1:0]        frac [3];
  logic signed [WORD_W-1:0] w [8];
  logic signed [E_W-1:0]    e [3];
  logic signed [WORD_W-1:0] growth;
  logic [K2_W-1:0]          k2;
  logic signed [DOT_W-1:0]  dot;
  logic [NUM_W-1:0]         numr;
  logic signed [VEC_W-1:0]  v [3];
  logic                     sat;
  logic                     pend;
  logic [2:0]               pend_idx;

  logic [SIDE_W-1:0]        side_clamp;
  logic [SIDE_W-1:0]        absk;
  logic [NW-1:0]            n_val;
  logic [DVD_W-1:0]         div_dvd;
  logic [DVS_W-1:0]         div_dvs;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic                     div_busy;
  logic [DVD_W-1:0]         quo;
  logic [DVS_W-1:0]         rem;
  logic [DVS_W-1:0]         abs_dot;
  logic [SIDE_W-1:0]        fr, fik;
  logic [LW-1:0]            pl, ph;
  logic [LW:0]              ph_w;
  logic [SIDE_W-1:0]        pr;
  logic                     mneg, movf, msat;
  logic [VEC_W:0]           mmag;
  logic signed [VEC_W-1:0]  mval;
  logic signed [WORD_W-1:0] la, lb, lres;
  logic [FRAC_W-1:0]        lf;
  logic signed [E_W-1:0]    ldiff;
  logic signed [E_W+FRAC_W:0] lprod;
  logic [1:0]               mi;
  logic signed [E_W-1:0]    mb;
  logic signed [DOT_W-1:0]  mprod;
  logic [WORD_W-1:0]        abse;
  logic [2:0]               ci;
  logic [LW-1:0]            ax_x, ax_y, ax_z;
  logic [AW-1:0]            raddr;
  logic [WORD_W-1:0]        rdata;
  logic                     wr_en;

  // side register clamped to the supported even range
  always_comb begin
    side_clamp = grid_points_per_side;
    if (side_clamp < SIDE_W'(2)) side_clamp = SIDE_W'(2);
    if (int'(side_clamp) > MAX_GRID_SIDE) side_clamp = SIDE_W'(MAX_GRID_SIDE);
    side_clamp[0] = 1'b0;
  end

  // divider operands by division kind
  always_comb begin
    absk    = SIDE_W'(k[cmd.axis] < 0 ? -int'(k[cmd.axis]) : int'(k[cmd.axis]));
    n_val   = NW'(int'(ik[cmd.axis]) * TABLE_SIDE);
    abs_dot = DVS_W'(dot < 0 ? -dot : dot);
    div_dvs = DVS_W'(side);
    case (cmd.kind)
      DIV_FOLD: begin
        div_dvd = DVD_W'(absk) << (DVD_W - SIDE_W);
        div_cnt = DIV_CNT_W'(SIDE_W);
      end
      DIV_PLACE: begin
        div_dvd = DVD_W'(n_val) << (DVD_W - NW);
        div_cnt = DIV_CNT_W'(NW);
      end
      DIV_FRAC: begin
        div_dvd = DVD_W'({rr[cmd.axis], {FRAC_W{1'b0}}}) << (DVD_W - SIDE_W - FRAC_W);
        div_cnt = DIV_CNT_W'(SIDE_W + FRAC_W);
      end
      default: begin
        div_dvd = {numr, {FRAC_W{1'b0}}};
        div_cnt = DIV_CNT_W'(DVD_W);
        div_dvs = abs_dot;
      end
    endcase
  end

  etl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.op == OP_DIV_START),
    .count     (div_cnt),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .quotient  (quo),
    .remainder (rem)
  );

  // fold: remainder made non-negative, z mirrored above half side
  always_comb begin
    fr  = rem[SIDE_W-1:0];
    fik = (k[cmd.axis] < 0 && fr != '0) ? side - fr : fr;
    if (cmd.axis == 2'd2 && fik > (side >> 1)) fik = side - fik;
  end

  // placement: nyquist gap skip, neighbour wrap or z hold
  always_comb begin
    pl = quo[LW-1:0];
    pr = rem[SIDE_W-1:0];
    if (int'(pl) == HALF && pr != '0) begin
      pl = LW'(HALF + 1);
      pr = '0;
    end
    ph_w = {1'b0, pl} + 1'b1;
    ph   = ph_w[LW-1:0];
    if (cmd.axis == 2'd2) begin
      if (int'(pl) >= HALF) begin
        pl = LW'(HALF);
        ph = LW'(HALF);
      end
    end else if (int'(ph_w) >= TABLE_SIDE) begin
      ph = '0;
    end
  end

  // scaled vector component from the final quotient
  always_comb begin
    mneg = (e[cmd.axis] < 0) != (dot < 0);
    movf = |quo[DVD_W-1:VEC_W];
    mmag = quo[VEC_W:0];
    msat = 1'b0;
    if (mneg) begin
      if (movf || mmag > (VEC_W+1)'(1) << (VEC_W - 1)) begin
        msat = 1'b1;
        mmag = (VEC_W+1)'(1) << (VEC_W - 1);
      end
    end else if (movf || mmag > ((VEC_W+1)'(1) << (VEC_W - 1)) - 1'b1) begin
      msat = 1'b1;
      mmag = ((VEC_W+1)'(1) << (VEC_W - 1)) - 1'b1;
    end
    mval = mneg ? -$signed(mmag[VEC_W-1:0]) : $signed(mmag[VEC_W-1:0]);
    if (dot == '0) begin
      mval = '0;
      msat = 1'b0;
    end
  end

  // one linear step: a + floor((b - a) * f / 2^16)
  always_comb begin
    case (cmd.step)
      3'd4: begin la = w[0]; lb = w[2]; lf = frac[1]; end
      3'd5: begin la = w[4]; lb = w[6]; lf = frac[1]; end
      3'd6: begin la = w[0]; lb = w[4]; lf = frac[0]; end
      default: begin
        la = w[{cmd.step[1:0], 1'b0}];
        lb = w[{cmd.step[1:0], 1'b1}];
        lf = frac[2];
      end
    endcase
    ldiff = E_W'(lb) - E_W'(la);
    lprod = ldiff * $signed({1'b0, lf});
    lres  = la + lprod[FRAC_W +: WORD_W];
  end

  // squared length and dot product share one multiplier
  always_comb begin
    mi    = (cmd.step < 3'd3) ? cmd.step[1:0] : 2'(cmd.step - 3'd3);
    mb    = (cmd.step < 3'd3) ? E_W'(k[mi]) : e[mi];
    mprod = k[mi] * mb;
    abse  = WORD_W'(e[cmd.axis] < 0 ? -e[cmd.axis] : e[cmd.axis]);
  end

  // table address of one corner
  always_comb begin
    ci    = cmd.step;
    ax_x  = ci[2] ? hi[0] : lo[0];
    ax_y  = ci[1] ? hi[1] : lo[1];
    ax_z  = ci[0] ? hi[2] : lo[2];
    raddr = AW'(((int'(ax_x) * TABLE_SIDE + int'(ax_y)) * ZPLANES + int'(ax_z)) * 4
                + int'(cmd.comp));
    wr_en = (cmd.op == OP_WRITE) && (int'(table_address) < DEPTH);
  end

  etl_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(table_address)),
    .wdata (table_word),
    .re    (cmd.op == OP_READ),
    .raddr (raddr),
    .rdata (rdata)
  );

  // read capture tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= (cmd.op == OP_READ);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (pend) w[pend_idx] <= rdata;
    if (cmd.op == OP_READ) pend_idx <= cmd.step;
    case (cmd.op)
      OP_LOAD: begin
        k[0] <= wave_x;
        k[1] <= wave_y;
        k[2] <= wave_z;
        side <= side_clamp;
        k2   <= '0;
        dot  <= '0;
        sat  <= 1'b0;
      end
      OP_PLAIN: begin
        for (int i = 0; i < 3; i++) begin
          v[i] <= {{(VEC_W-K_W-FRAC_W){k[i][K_W-1]}}, k[i], {FRAC_W{1'b0}}};
        end
        growth <= ONE_Q28;
      end
      OP_DIV_END: begin
        case (cmd.kind)
          DIV_FOLD: ik[cmd.axis] <= fik;
          DIV_PLACE: begin
            lo[cmd.axis] <= pl;
            hi[cmd.axis] <= ph;
            rr[cmd.axis] <= pr;
          end
          DIV_FRAC: frac[cmd.axis] <= quo[FRAC_W-1:0];
          default: begin
            v[cmd.axis] <= mval;
            sat <= sat | msat;
          end
        endcase
      end
      OP_LERP: begin
        if (cmd.step == 3'd6) begin
          if (cmd.comp == 2'd3) begin
            growth <= lres;
          end else if (cmd.comp == 2'd2 && k[2] < 0) begin
            e[2] <= -E_W'(lres);
          end else begin
            e[cmd.comp] <= E_W'(lres);
          end
        end else if (cmd.step == 3'd4) begin
          w[0] <= lres;
        end else if (cmd.step == 3'd5) begin
          w[4] <= lres;
        end else begin
          w[{cmd.step[1:0], 1'b0}] <= lres;
        end
      end
      OP_MAC: begin
        if (cmd.step < 3'd3) k2 <= k2 + mprod[K2_W-1:0];
        else dot <= dot + mprod;
      end
      OP_NUM: numr <= k2 * abse;
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      out_ch.vec_x        <= v[0];
      out_ch.vec_y        <= v[1];
      out_ch.vec_z        <= v[2];
      out_ch.growth_value <= growth;
      out_ch.saturated    <= sat;
    end
  end

  assign status.div_busy = div_busy;
  assign status.out_free = !out_ch.valid || out_ch.ready;
  assign status.mode     = mode_table_enable;
endmodule

@@ sv/eigenmode_trilinear_lookup.sv @@
// Eigenmode trilinear lookup. A write item (opcode 0) stores one Q4.28 table word;
// addresses beyond the table are dropped. A query item (opcode 1) in plain mode returns
// the wavevector in Q24.16 with eigenvalue one. In mode-table mode a query runs through
// one shared bit-serial divider (index fold, grid placement and fraction on each axis,
// then one 74-step division per vector component) and 32 reads of the single table port
// with seven linear steps per component. Items are taken one at a time, while the
// previous result may still wait in the output register. Table contents are undefined
// until written. Config goes through an APB port: register 0 at 0x0, register 1 at 0x4;
// the user must see that they are written only when the block is idle, as the block does not enforce it.
`include "eigenmode_trilinear_lookup_assert.svh"

module eigenmode_trilinear_lookup #(
  parameter int TABLE_SIDE    = 32,
  parameter int MAX_GRID_SIDE = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  etl_in_if.sink                        in_ch,
  etl_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [etl_pkg::PADDR_W-1:0]   paddr,
  input  logic [etl_pkg::PDATA_W-1:0]   pwdata,
  output logic [etl_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import etl_pkg::*;

  logic              mode_table_enable;
  logic [SIDE_W-1:0] grid_points_per_side;
  cmd_t              cmd;
  status_t           status;
  logic              in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_table_enable    <= 1'b0;
      grid_points_per_side <= SIDE_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MODE) mode_table_enable <= pwdata[0];
      else grid_points_per_side <= pwdata[SIDE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? PDATA_W'(mode_table_enable)
                                         : PDATA_W'(grid_points_per_side);

  etl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  assign in_ch.ready = in_ready;

  etl_dp #(.TABLE_SIDE(TABLE_SIDE), .MAX_GRID_SIDE(MAX_GRID_SIDE)) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .table_address        (in_ch.table_address),
    .table_word           (in_ch.table_word),
    .wave_x               (in_ch.wave_x),
    .wave_y               (in_ch.wave_y),
    .wave_z               (in_ch.wave_z),
    .mode_table_enable    (mode_table_enable),
    .grid_points_per_side (grid_points_per_side),
    .out_ch               (out_ch)
  );

  // a query transfer is followed by a busy cycle
  `ETL_ASSERT_NEXT(a_query_busy, clk, rst, in_ch.valid && in_ch.ready && in_ch.opcode == OPC_QUERY, !in_ch.ready)
  // a result is loaded only when the output register is free
  `ETL_ASSERT_NOW(a_finish_free, clk, rst, cmd.op == OP_FINISH, status.out_free)
  // a loaded result is offered next cycle
  `ETL_ASSERT_NEXT(a_finish_valid, clk, rst, cmd.op == OP_FINISH, out_ch.valid)
endmodule

@@ tb/eigenmode_trilinear_lookup_tb.sv @@
// self-checking testbench for the eigenmode trilinear lookup: directed rows, full
// table load, then random writes and queries over several register settings
// depends on etl_pkg, etl_if and eigenmode_trilinear_lookup
module eigenmode_trilinear_lookup_tb;
  import etl_pkg::*;

  localparam int TSIDE   = 32;
  localparam int ZPL     = TSIDE / 2 + 1;
  localparam int TDEPTH  = TSIDE * TSIDE * ZPL * 4;
  localparam int DRAIN   = 600;
  localparam longint unsigned OUT_LIM = 64'd549755813888;

  typedef struct {
    logic [VEC_W-1:0]  vx;
    logic [VEC_W-1:0]  vy;
    logic [VEC_W-1:0]  vz;
    logic [WORD_W-1:0] growth;
    logic              sat;
  } mode_result_t;

  typedef struct {
    logic         op;
    int           addr;
    logic [31:0]  word;
    int           kx;
    int           ky;
    int           kz;
    bit           typed;
    mode_result_t res;
  } stim_row_t;

  typedef struct {
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned frac;
  } axis_pos_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  etl_in_if  in_ch ();
  etl_out_if out_ch ();

  eigenmode_trilinear_lookup dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [31:0]   eigen_mirror [0:TDEPTH-1];
  logic          cfg_mode = 1'b0;
  logic [12:0]   cfg_side = SIDE_RESET;
  mode_result_t  expected_modes [$];
  int            failures = 0;
  int            burst_left = 0;
  int            stall_pct = 0;
  int            stall_cnt = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OPC_WRITE;
    in_ch.table_address = '0;
    in_ch.table_word = '0;
    in_ch.wave_x = '0;
    in_ch.wave_y = '0;
    in_ch.wave_z = '0;
    out_ch.ready = 1'b0;
  end

  // run limit
  initial begin
    #(8 * 6000000);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint fold_index(longint k, longint side);
    longint m;
    m = k % side;
    return (m < 0) ? m + side : m;
  endfunction

  function automatic axis_pos_t place_axis(longint ik, longint side, bit zaxis);
    axis_pos_t a;
    longint unsigned n, l, r, h;
    n = TSIDE * ik;
    l = n / side;
    r = n % side;
    // nyquist gap: move up to the next plane with no fraction
    if (l == TSIDE / 2 && r != 0) begin
      l++;
      r = 0;
    end
    h = l + 1;
    if (zaxis) begin
      if (l >= TSIDE / 2) begin
        l = TSIDE / 2;
        h = l;
      end
    end else begin
      if (l >= TSIDE) l = TSIDE - 1;
      if (h >= TSIDE) h = 0;
    end
    a.lo = l;
    a.hi = h;
    a.frac = (r << FRAC_W) / side;
    return a;
  endfunction

  function automatic longint table_word_at(longint unsigned x, longint unsigned y,
                                           longint unsigned z, int c);
    longint unsigned idx;
    idx = ((x * TSIDE + y) * ZPL + z) * 4 + c;
    if (idx >= TDEPTH) return 0;
    return longint'($signed(eigen_mirror[idx]));
  endfunction

  function automatic longint lerp_step(longint a, longint b, longint unsigned f);
    longint p;
    p = (b - a) * longint'(f);
    return a + (p >>> 16);
  endfunction

  function automatic longint interp_word(axis_pos_t px, axis_pos_t py, axis_pos_t pz, int c);
    longint c00, c01, c10, c11;
    c00 = lerp_step(table_word_at(px.lo, py.lo, pz.lo, c),
                    table_word_at(px.lo, py.lo, pz.hi, c), pz.frac);
    c01 = lerp_step(table_word_at(px.lo, py.hi, pz.lo, c),
                    table_word_at(px.lo, py.hi, pz.hi, c), pz.frac);
    c10 = lerp_step(table_word_at(px.hi, py.lo, pz.lo, c),
                    table_word_at(px.hi, py.lo, pz.hi, c), pz.frac);
    c11 = lerp_step(table_word_at(px.hi, py.hi, pz.lo, c),
                    table_word_at(px.hi, py.hi, pz.hi, c), pz.frac);
    return lerp_step(lerp_step(c00, c01, py.frac), lerp_step(c10, c11, py.frac), px.frac);
  endfunction

  // k2 * e / dot in Q24.16, clipped to 40 bits
  function automatic longint scale_component(longint k2, longint e, longint dot,
                                             inout logic sat);
    longint unsigned num, den, q1, r1, mag;
    bit neg;
    if (k2 == 0 || dot == 0 || e == 0) return 0;
    neg = (e < 0) != (dot < 0);
    num = longint'(k2) * ((e < 0) ? -e : e);
    den = (dot < 0) ? -dot : dot;
    q1 = num / den;
    r1 = num % den;
    if (q1 >= (64'd1 << 24)) mag = OUT_LIM + 1;
    else mag = (q1 << FRAC_W) + ((r1 << FRAC_W) / den);
    if (neg) begin
      if (mag > OUT_LIM) begin
        sat = 1'b1;
        mag = OUT_LIM;
      end
      return -longint'(mag);
    end
    if (mag > OUT_LIM - 1) begin
      sat = 1'b1;
      mag = OUT_LIM - 1;
    end
    return longint'(mag);
  endfunction

  function automatic mode_result_t predict_mode(int kx, int ky, int kz);
    mode_result_t r;
    longint side, ikz, k2, dot;
    longint e [4];
    longint v [3];
    axis_pos_t px, py, pz;
    logic sat;
    sat = 1'b0;
    if (!cfg_mode) begin
      v[0] = longint'(kx) * 65536;
      v[1] = longint'(ky) * 65536;
      v[2] = longint'(kz) * 65536;
      r.growth = ONE_Q28;
    end else begin
      side = cfg_side;
      if (side < 2) side = 2;
      if (side > 4096) side = 4096;
      side = side & ~longint'(1);
      ikz = fold_index(kz, side);
      if (ikz > side / 2) ikz = side - ikz;
      px = place_axis(fold_index(kx, side), side, 1'b0);
      py = place_axis(fold_index(ky, side), side, 1'b0);
      pz = place_axis(ikz, side, 1'b1);
      for (int i = 0; i < 4; i++) e[i] = interp_word(px, py, pz, i);
      if (kz < 0) e[2] = -e[2];
      k2 = longint'(kx) * kx + longint'(ky) * ky + longint'(kz) * kz;
      dot = kx * e[0] + ky * e[1] + kz * e[2];
      for (int i = 0; i < 3; i++) v[i] = scale_component(k2, e[i], dot, sat);
      r.growth = e[3][31:0];
    end
    r.vx = v[0][39:0];
    r.vy = v[1][39:0];
    r.vz = v[2][39:0];
    r.sat = sat;
    return r;
  endfunction

  // one transfer on the item channel, bursts separated by random gaps
  task automatic send_item(logic op, int addr, logic [31:0] word, int kx, int ky, int kz,
                           bit typed, mode_result_t res, bit no_gap);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.table_address <= addr[ADDR_W-1:0];
    in_ch.table_word <= word;
    in_ch.wave_x <= kx[K_W-1:0];
    in_ch.wave_y <= ky[K_W-1:0];
    in_ch.wave_z <= kz[K_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
    if (op == OPC_WRITE) begin
      if (addr < TDEPTH) eigen_mirror[addr] = word;
    end else begin
      expected_modes.push_back(typed ? res : predict_mode(kx, ky, kz));
    end
    if (!no_gap) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
        gap = $urandom_range(1, 9);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // lower valid, drain results and let the datapath settle
  task automatic wait_idle();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    while (expected_modes.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(logic mode, logic [12:0] side);
    apb_write(3'h0, {31'd0, mode});
    apb_write(3'h4, {19'd0, side});
    cfg_mode = mode;
    cfg_side = side;
  endtask

  function automatic int rand_k();
    case ($urandom_range(0, 7))
      0: return -2048;
      1: return 2048;
      2: return $urandom_range(0, 8) - 4;
      3: return $urandom_range(0, 128) - 64;
      default: return $urandom_range(0, 4096) - 2048;
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return ONE_Q28;
      default: return $urandom;
    endcase
  endfunction

  // result side: random stall level on ready, then check each transfer
  always @(posedge clk) begin
    mode_result_t exp_r;
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 25;
        2: stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
    end
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_modes.size() == 0) begin
        $error("result transfer with nothing expected");
        failures++;
      end else begin
        exp_r = expected_modes.pop_front();
        if (out_ch.vec_x !== exp_r.vx) begin
          $error("vec_x expected %h actual %h", exp_r.vx, out_ch.vec_x);
          failures++;
        end
        if (out_ch.vec_y !== exp_r.vy) begin
          $error("vec_y expected %h actual %h", exp_r.vy, out_ch.vec_y);
          failures++;
        end
        if (out_ch.vec_z !== exp_r.vz) begin
          $error("vec_z expected %h actual %h", exp_r.vz, out_ch.vec_z);
          failures++;
        end
        if (out_ch.growth_value !== exp_r.growth) begin
          $error("growth_value expected %h actual %h", exp_r.growth, out_ch.growth_value);
          failures++;
        end
        if (out_ch.saturated !== exp_r.sat) begin
          $error("saturated expected %b actual %b", exp_r.sat, out_ch.saturated);
          failures++;
        end
      end
    end
  end

  initial begin
    stim_row_t plain_rows [10];
    stim_row_t mode_rows [12];
    mode_result_t none;
    logic [12:0] sides [9];
    int base;
    none = '{40'h0, 40'h0, 40'h0, 32'h0, 1'b0};
    // plain mode after reset: results readable at a glance
    plain_rows = '{
      '{OPC_QUERY, 0, 32'h0, 0, 0, 0, 1'b1, '{40'h0, 40'h0, 40'h0, ONE_Q28, 1'b0}},
      '{OPC_QUERY, 0, 32'h0, 2048, -2048, 2047, 1'b1,
        '{40'h00_0800_0000, 40'hff_f800_0000, 40'h00_07ff_0000, ONE_Q28, 1'b0}},
      '{OPC_QUERY, 0, 32'h0, -2048, -2048, -2048, 1'b1,
        '{40'hff_f800_0000, 40'hff_f800_0000, 40'hff_f800_0000, ONE_Q28, 1'b0}},
      '{OPC_QUERY, 0, 32'h0, -1, 1, 2048, 1'b1,
        '{40'hff_ffff_0000, 40'h00_0001_0000, 40'h00_0800_0000, ONE_Q28, 1'b0}},
      // writes beyond the table are dropped, then two writes inside it
      '{OPC_WRITE, 131071, 32'hdead_beef, 0, 0, 0, 1'b0, none},
      '{OPC_WRITE, TDEPTH, 32'h1234_5678, 0, 0, 0, 1'b0, none},
      '{OPC_WRITE, TDEPTH - 1, 32'h8000_0000, 0, 0, 0, 1'b0, none},
      '{OPC_WRITE, 0, 32'h7fff_ffff, 0, 0, 0, 1'b0, none},
      '{OPC_QUERY, 0, 32'h0, 1, 0, -1, 1'b1,
        '{40'h00_0001_0000, 40'h0, 40'hff_ffff_0000, ONE_Q28, 1'b0}},
      '{OPC_QUERY, 0, 32'h0, 2047, 2048, -2047, 1'b0, none}
    };
    // entry (1,0,0) all zero, entry (2,0,0) tiny x with huge y
    base = TSIDE * ZPL * 4;
    mode_rows = '{
      '{OPC_WRITE, base + 0, 32'h0, 0, 0, 0, 1'b0, none},
      '{OPC_WRITE, base + 1, 32'h0, 0, 0, 0, 1'b0, none},
      '{OPC_WRITE, base + 2, 32'h0, 0, 0, 0, 1'b0, none},
      '{OPC_WRITE, base + 3, 32'h0, 0, 0, 0, 1'b0, none},
      '{OPC_WRITE, 2 * base + 0, 32'h1, 0, 0, 0, 1'b0, none},
      '{OPC_WRITE, 2 * base + 1, 32'h7fff_ffff, 0, 0, 0, 1'b0, none},
      '{OPC_QUERY, 0, 32'h0, 1, 0, 0, 1'b1, none},
      '{OPC_QUERY, 0, 32'h0, 2, 0, 0, 1'b0, none},
      '{OPC_QUERY, 0, 32'h0, 0, 0, 0, 1'b0, none},
      '{OPC_QUERY, 0, 32'h0, 16, -17, 17, 1'b0, none},
      '{OPC_QUERY, 0, 32'h0, 31, 33, -16, 1'b0, none},
      '{OPC_QUERY, 0, 32'h0, -2048, 2048, -2048, 1'b0, none}
    };
    // modes, sides including out-of-range and odd values
    sides = '{13'd64, 13'd2, 13'd4096, 13'd0, 13'd1, 13'd8191, 13'd37, 13'd4095, 13'd100};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plain_rows[i])
      send_item(plain_rows[i].op, plain_rows[i].addr, plain_rows[i].word, plain_rows[i].kx,
                plain_rows[i].ky, plain_rows[i].kz, plain_rows[i].typed, plain_rows[i].res,
                1'b0);

    // fill the whole table so that no query reads an unwritten word
    for (int a = 0; a < TDEPTH; a++)
      send_item(OPC_WRITE, a, rand_word(), 0, 0, 0, 1'b0, none, 1'b1);
    wait_idle();

    // table mode on a grid matching the table, so positions are exact
    set_config(1'b1, 13'd32);
    foreach (mode_rows[i])
      send_item(mode_rows[i].op, mode_rows[i].addr, mode_rows[i].word, mode_rows[i].kx,
                mode_rows[i].ky, mode_rows[i].kz, mode_rows[i].typed, mode_rows[i].res,
                1'b0);
    wait_idle();

    // random phases over register settings
    for (int ph = 0; ph < 11; ph++) begin
      if (ph < 9) set_config(ph == 8 ? 1'b0 : 1'b1, sides[ph]);
      else set_config(1'b1, 13'($urandom_range(1, 2048) * 2));
      for (int n = 0; n < 90; n++) begin
        if ($urandom_range(0, 4) == 0)
          send_item(OPC_WRITE, $urandom_range(0, 131071), rand_word(), 0, 0, 0, 1'b0, none,
                    1'b0);
        else
          send_item(OPC_QUERY, $urandom_range(0, 131071), $urandom, rand_k(), rand_k(),
                    rand_k(), 1'b0, none, 1'b0);
      end
      wait_idle();
    end

    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
